// File: src/rgb_box_blur_3x3_macros.svh
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3 assertion macros
// Shared property forms for the blur block checks.
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_BLUR_3X3_MACROS_SVH
`define RGB_BOX_BLUR_3X3_MACROS_SVH

// same-cycle implication
`define RBB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg
// Types and constants shared by the RGB 3x3 box blur modules.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int PEND_W     = $clog2(MAX_WIDTH + 2);
  localparam int CFG_W      = 12;
  localparam int ROW_W      = 12;
  localparam int CH_W       = 8;
  localparam int LANES      = 3;
  localparam int PIX_W      = CH_W * LANES;
  localparam int TAPS       = 9;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic            command;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_end;
  } pix_out_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic blur;
    logic last;
  } ctrl_t;

  typedef logic [TAPS-1:0][PIX_W-1:0] window_t;
  typedef logic [TAPS-1:0][CH_W-1:0]  taps_t;
  typedef logic [LANES-1:0][CH_W-1:0] lane_res_t;

endpackage

// File: src/rbb_window.sv
// ----------------------------------------------------------------------------
// rbb_window
// Two line stores and the 3x3 pixel window they feed.
// ----------------------------------------------------------------------------
module rbb_window (
  input  logic                       clk,
  input  logic                       rst,
  input  rbb_pkg::ctrl_t             c_in,
  input  logic [rbb_pkg::ADDR_W-1:0] addr,
  input  logic [rbb_pkg::PIX_W-1:0]  pix,
  output rbb_pkg::window_t           win,
  output rbb_pkg::ctrl_t             w_ctrl
);

  logic [rbb_pkg::PIX_W-1:0]  upper_mem [rbb_pkg::MAX_WIDTH];
  logic [rbb_pkg::PIX_W-1:0]  middle_mem [rbb_pkg::MAX_WIDTH];
  logic [rbb_pkg::PIX_W-1:0]  up_rd;
  logic [rbb_pkg::PIX_W-1:0]  mid_rd;
  logic [rbb_pkg::PIX_W-1:0]  s1_pix;
  logic [rbb_pkg::ADDR_W-1:0] s1_addr;
  rbb_pkg::ctrl_t             s1_ctrl;

  always_ff @(posedge clk) begin
    if (c_in.valid) begin
      if (s1_ctrl.valid && s1_addr == addr) begin
        up_rd <= mid_rd;
      end else begin
        up_rd <= upper_mem[addr];
      end
    end
    if (s1_ctrl.valid) begin
      upper_mem[s1_addr] <= mid_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (c_in.valid) begin
      mid_rd           <= middle_mem[addr];
      middle_mem[addr] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix  <= pix;
    s1_addr <= addr;
    if (rst) begin
      s1_ctrl <= '0;
      w_ctrl  <= '0;
    end else begin
      s1_ctrl <= c_in;
      w_ctrl  <= s1_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_ctrl.valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= up_rd;
      win[5] <= mid_rd;
      win[8] <= s1_pix;
    end
  end

endmodule

// File: src/rbb_lane.sv
// ----------------------------------------------------------------------------
// rbb_lane
// One color channel: nine-tap sum, then floor divide by nine or pass center.
// ----------------------------------------------------------------------------
module rbb_lane (
  input  logic                     clk,
  input  rbb_pkg::taps_t           taps,
  input  logic                     blur,
  output logic [rbb_pkg::CH_W-1:0] res
);

  localparam int SUM_W      = rbb_pkg::CH_W + 4;
  localparam int DIV_SHIFT  = 14;
  localparam int DIV_MUL    = ((1 << DIV_SHIFT) + 8) / 9;
  localparam int MUL_W      = $clog2(DIV_MUL + 1);
  localparam int PROD_W     = SUM_W + MUL_W;

  logic [SUM_W-1:0]        sum_c;
  logic [SUM_W-1:0]        sum;
  logic [rbb_pkg::CH_W-1:0] center;
  logic                    blur_d;
  logic [PROD_W-1:0]       prod;

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < rbb_pkg::TAPS; i++) begin
      sum_c = sum_c + SUM_W'(taps[i]);
    end
  end

  assign prod = PROD_W'(sum) * PROD_W'(DIV_MUL);

  always_ff @(posedge clk) begin
    sum    <= sum_c;
    center <= taps[4];
    blur_d <= blur;
    res    <= blur_d ? prod[DIV_SHIFT +: rbb_pkg::CH_W] : center;
  end

endmodule

// File: src/rbb_merge.sv
// ----------------------------------------------------------------------------
// rbb_merge
// Align lane results with their flags and queue finished pixels for output.
// ----------------------------------------------------------------------------
module rbb_merge (
  input  logic               clk,
  input  logic               rst,
  input  rbb_pkg::ctrl_t     w_ctrl,
  input  rbb_pkg::lane_res_t lane_res,
  input  logic               res_stall,
  output logic               res_valid,
  output rbb_pkg::pix_out_t  res
);

  rbb_pkg::ctrl_t              d1;
  rbb_pkg::ctrl_t              d2;
  rbb_pkg::pix_out_t           fifo_mem [rbb_pkg::FIFO_DEPTH];
  logic [rbb_pkg::FIFO_AW-1:0] wr_ptr;
  logic [rbb_pkg::FIFO_AW-1:0] rd_ptr;
  logic [rbb_pkg::FIFO_AW:0]   count;
  logic                        push;
  logic                        pop;
  rbb_pkg::pix_out_t           merged;

  assign push      = d2.valid && d2.emit;
  assign res_valid = count != '0;
  assign pop       = res_valid && !res_stall;
  assign res       = fifo_mem[rd_ptr];

  always_comb begin
    merged.red_out   = lane_res[0];
    merged.green_out = lane_res[1];
    merged.blue_out  = lane_res[2];
    merged.frame_end = d2.last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1     <= '0;
      d2     <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      d1 <= w_ctrl;
      d2 <= d1;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/rgb_box_blur_3x3.sv
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3
// 3x3 mean blur on a raster RGB pixel stream, border pixels passed through.
// ----------------------------------------------------------------------------
//   channel  signals                              direction  transfer when
//   pix      pix_valid, pix_stall, pix            in         pix_valid & !pix_stall
//   res      res_valid, res_stall, res            out        res_valid & !res_stall
//   cfg      cfg_valid, cfg_ready, cfg_index/data in         cfg_valid & cfg_ready
//
// One pixel or flush per clock while pix_stall is low; a result passes through
// the window, the lane sum, the divide and the output queue stages.
// pix_stall rises only when eight results are in flight or queued.
// Synchronous reset clears counters, window and queue; line stores need none.
// Each pixel's result follows frame_width+1 pixel transfers later (width
// clamped to 3..2048); flushes drain the last row.
// ----------------------------------------------------------------------------
`include "rgb_box_blur_3x3_macros.svh"

module rgb_box_blur_3x3 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  rbb_pkg::pix_in_t              pix,
  output logic                          res_valid,
  input  logic                          res_stall,
  output rbb_pkg::pix_out_t             res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  rbb_pkg::cfg_reg_t             cfg_index,
  input  logic [rbb_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CMP_W = rbb_pkg::CFG_W + rbb_pkg::WID_W;
  localparam int RI_W  = rbb_pkg::ROW_W + 1;

  logic [rbb_pkg::CFG_W-1:0]  frame_width;
  logic [rbb_pkg::CFG_W-1:0]  frame_height;
  logic [rbb_pkg::ADDR_W-1:0] column_count;
  logic [rbb_pkg::ADDR_W-1:0] column_count_next;
  logic [rbb_pkg::ROW_W-1:0]  row_count;
  logic [rbb_pkg::ROW_W-1:0]  row_count_next;
  logic [rbb_pkg::PEND_W-1:0] pending;
  logic [rbb_pkg::PEND_W-1:0] pending_next;
  logic [rbb_pkg::OCC_W-1:0]  occ;
  logic [rbb_pkg::OCC_W-1:0]  occ_next;

  logic [rbb_pkg::WID_W-1:0]  eff_w;
  logic [rbb_pkg::ROW_W-1:0]  eff_h;
  logic [rbb_pkg::WID_W-1:0]  col_inc;
  logic [RI_W-1:0]            row_inc;
  logic                       col_last;
  logic                       row_last;
  logic                       draining;
  logic                       pix_transfer;
  logic                       res_transfer;
  logic                       act;
  logic                       has_out;
  logic                       interior;
  rbb_pkg::ctrl_t             c_in;
  logic [rbb_pkg::PIX_W-1:0]  pix_word;
  rbb_pkg::window_t           win;
  rbb_pkg::ctrl_t             w_ctrl;
  rbb_pkg::taps_t             lane_taps [rbb_pkg::LANES];
  rbb_pkg::lane_res_t         lane_res;

  assign cfg_ready    = 1'b1;
  assign pix_stall    = occ >= rbb_pkg::OCC_W'(rbb_pkg::FIFO_DEPTH);
  assign pix_transfer = pix_valid && !pix_stall;
  assign res_transfer = res_valid && !res_stall;
  assign draining     = pending != '0;
  assign act          = pix_transfer && (draining || !pix.command);

  always_comb begin
    if (frame_width < rbb_pkg::CFG_W'(3)) begin
      eff_w = rbb_pkg::WID_W'(3);
    end else if (CMP_W'(frame_width) > CMP_W'(rbb_pkg::MAX_WIDTH)) begin
      eff_w = rbb_pkg::WID_W'(rbb_pkg::MAX_WIDTH);
    end else begin
      eff_w = rbb_pkg::WID_W'(frame_width);
    end
    eff_h = (frame_height < rbb_pkg::CFG_W'(3)) ? rbb_pkg::ROW_W'(3) : frame_height;
  end

  assign col_inc  = rbb_pkg::WID_W'(column_count) + rbb_pkg::WID_W'(1);
  assign row_inc  = RI_W'(row_count) + RI_W'(1);
  assign col_last = col_inc >= eff_w;
  assign row_last = row_inc >= RI_W'(eff_h);
  assign has_out  = (row_count >= rbb_pkg::ROW_W'(2)) ||
                    (row_count == rbb_pkg::ROW_W'(1) && column_count != '0);
  assign interior = (column_count >= rbb_pkg::ADDR_W'(2)) && (col_inc <= eff_w) &&
                    (row_count >= rbb_pkg::ROW_W'(2)) && (row_count < eff_h);
  assign pix_word = draining ? '0 : {pix.red_in, pix.green_in, pix.blue_in};

  always_comb begin
    c_in.valid = act;
    c_in.emit  = draining || has_out;
    c_in.blur  = !draining && interior;
    c_in.last  = draining && pending == rbb_pkg::PEND_W'(1);
  end

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    pending_next      = pending;
    if (act) begin
      if (draining) begin
        column_count_next = col_last ? '0 : col_inc[rbb_pkg::ADDR_W-1:0];
        pending_next      = pending - 1'b1;
        if (pending == rbb_pkg::PEND_W'(1)) begin
          column_count_next = '0;
          row_count_next    = '0;
        end
      end else if (col_last) begin
        column_count_next = '0;
        if (row_last) begin
          row_count_next = '0;
          pending_next   = rbb_pkg::PEND_W'(eff_w) + 1'b1;
        end else begin
          row_count_next = row_inc[rbb_pkg::ROW_W-1:0];
        end
      end else begin
        column_count_next = col_inc[rbb_pkg::ADDR_W-1:0];
      end
    end
  end

  always_comb begin
    occ_next = occ;
    if ((act && c_in.emit) && !res_transfer) begin
      occ_next = occ + 1'b1;
    end else if (!(act && c_in.emit) && res_transfer) begin
      occ_next = occ - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rbb_pkg::WIDTH_RESET;
      frame_height <= rbb_pkg::HEIGHT_RESET;
      column_count <= '0;
      row_count    <= '0;
      pending      <= '0;
      occ          <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      pending      <= pending_next;
      occ          <= occ_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rbb_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          rbb_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  rbb_window u_window (
    .clk    (clk),
    .rst    (rst),
    .c_in   (c_in),
    .addr   (column_count),
    .pix    (pix_word),
    .win    (win),
    .w_ctrl (w_ctrl)
  );

  for (genvar g = 0; g < rbb_pkg::LANES; g++) begin : g_lane
    for (genvar i = 0; i < rbb_pkg::TAPS; i++) begin : g_tap
      assign lane_taps[g][i] =
        win[i][rbb_pkg::PIX_W-1-g*rbb_pkg::CH_W -: rbb_pkg::CH_W];
    end
    rbb_lane u_lane (
      .clk  (clk),
      .taps (lane_taps[g]),
      .blur (w_ctrl.blur),
      .res  (lane_res[g])
    );
  end

  rbb_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .w_ctrl    (w_ctrl),
    .lane_res  (lane_res),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res       (res)
  );

  `RBB_ASSERT_NOW(a_occ_bound, clk, rst, 1'b1, occ <= rbb_pkg::OCC_W'(rbb_pkg::FIFO_DEPTH), "occupancy beyond queue depth")
  `RBB_ASSERT_NOW(a_res_counted, clk, rst, res_valid, occ != '0, "result shown with no occupancy")
  `RBB_ASSERT_NEXT(a_frame_drain, clk, rst, act && !draining && col_last && row_last, pending == rbb_pkg::PEND_W'(eff_w) + 1'b1, "drain count not loaded at frame end")
  `RBB_ASSERT_NEXT(a_drain_done, clk, rst, act && draining && pending == rbb_pkg::PEND_W'(1), column_count == '0 && row_count == '0 && pending == '0, "position not cleared after drain")

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 RGB box blur. Random frames of random size
// stream through the block with bursts of idling on both channels. A
// scoreboard tracks line stores, window and counters to predict each smoothed
// or passed-through pixel, then compares the block's results in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rbb_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;

  class box_blur_scoreboard;
    bit [PIX_W-1:0] upper_line [MAX_WIDTH];
    bit [PIX_W-1:0] middle_line [MAX_WIDTH];
    bit [PIX_W-1:0] window [TAPS];
    int unsigned col;
    int unsigned row;
    int unsigned drain_left;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pix_out_t expected_pixels [$];
    int unsigned mismatches;

    function new();
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col = 0;
      row = 0;
      drain_left = 0;
      mismatches = 0;
      foreach (window[i]) window[i] = '0;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
    endfunction

    function int unsigned eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function void set_reg(cfg_reg_t which, logic [CFG_W-1:0] value);
      case (which)
        REG_FRAME_WIDTH: width_reg = value;
        REG_FRAME_HEIGHT: height_reg = value;
        default: ;
      endcase
    endfunction

    function void shift_window(bit [PIX_W-1:0] pixel);
      int unsigned idx;
      bit [PIX_W-1:0] up;
      bit [PIX_W-1:0] mid;
      idx = (col >= MAX_WIDTH) ? 0 : col;
      up = upper_line[idx];
      mid = middle_line[idx];
      for (int r = 0; r < 3; r++) begin
        window[r*3] = window[r*3+1];
        window[r*3+1] = window[r*3+2];
      end
      window[2] = up;
      window[5] = mid;
      window[8] = pixel;
      upper_line[idx] = mid;
      middle_line[idx] = pixel;
    endfunction

    function bit [PIX_W-1:0] mean_of_window();
      bit [PIX_W-1:0] mean;
      int unsigned sum;
      mean = '0;
      for (int sh = 0; sh < PIX_W; sh += CH_W) begin
        sum = 0;
        for (int i = 0; i < TAPS; i++) sum += (window[i] >> sh) & 8'hFF;
        mean |= PIX_W'(sum / 9) << sh;
      end
      return mean;
    endfunction

    function void queue_pixel(bit [PIX_W-1:0] pixel, bit last);
      pix_out_t item;
      item.red_out = pixel[23:16];
      item.green_out = pixel[15:8];
      item.blue_out = pixel[7:0];
      item.frame_end = last;
      expected_pixels.push_back(item);
    endfunction

    function void note_transfer(pix_in_t item);
      int unsigned w;
      int unsigned h;
      int unsigned c0;
      int unsigned r0;
      bit has_out;
      bit interior;
      w = eff_width();
      h = eff_height();
      if (drain_left != 0) begin
        shift_window('0);
        col = (col + 1 >= w) ? 0 : col + 1;
        drain_left--;
        queue_pixel(window[4], drain_left == 0);
        if (drain_left == 0) begin
          col = 0;
          row = 0;
        end
        return;
      end
      if (item.command) return;
      c0 = col;
      r0 = row;
      shift_window({item.red_in, item.green_in, item.blue_in});
      has_out = r0 >= 2 || (r0 == 1 && c0 >= 1);
      interior = c0 >= 2 && c0 + 1 <= w && r0 >= 2 && r0 <= h - 1;
      if (has_out) queue_pixel(interior ? mean_of_window() : window[4], 1'b0);
      if (c0 + 1 >= w) begin
        col = 0;
        if (r0 + 1 >= h) begin
          row = 0;
          drain_left = w + 1;
        end else begin
          row = r0 + 1;
        end
      end else begin
        col = c0 + 1;
      end
    endfunction

    function void check_result(pix_out_t got);
      pix_out_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result r=%0d g=%0d b=%0d end=%0d",
                   got.red_out, got.green_out, got.blue_out, got.frame_end);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
          got.blue_out !== want.blue_out || got.frame_end !== want.frame_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected r=%0d g=%0d b=%0d end=%0d, got r=%0d g=%0d b=%0d end=%0d",
                   want.red_out, want.green_out, want.blue_out, want.frame_end,
                   got.red_out, got.green_out, got.blue_out, got.frame_end);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic pix_valid;
  logic pix_stall;
  pix_in_t pix;
  logic res_valid;
  logic res_stall;
  pix_out_t res;
  logic cfg_valid;
  logic cfg_ready;
  cfg_reg_t cfg_index;
  logic [CFG_W-1:0] cfg_data;

  box_blur_scoreboard board = new();
  bit calm;
  int unsigned idle_pct_in;
  int unsigned idle_pct_out;
  int unsigned stim_items;
  longint unsigned cycles;

  rgb_box_blur_3x3 i_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) board.check_result(res);
  end

  initial begin : result_side
    int gap;
    gap = 0;
    forever begin
      @(negedge clk);
      if (gap > 0) begin
        res_stall = 1'b1;
        gap--;
      end else if (!calm && $urandom_range(0, 99) < idle_pct_out) begin
        res_stall = 1'b1;
        gap = $urandom_range(1, 14) - 1;
      end else begin
        res_stall = 1'b0;
      end
    end
  end

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_in_t pixel_of(logic cmd, logic [PIX_W-1:0] rgb);
    pix_in_t item;
    item.command = cmd;
    {item.red_in, item.green_in, item.blue_in} = rgb;
    return item;
  endfunction

  function automatic pix_in_t random_pixel(logic cmd);
    return pixel_of(cmd, {rand_channel(), rand_channel(), rand_channel()});
  endfunction

  task automatic send_item(input pix_in_t item);
    int gap;
    if (!calm && $urandom_range(0, 99) < idle_pct_in) begin
      gap = $urandom_range(1, 14);
      repeat (gap) begin
        @(negedge clk);
        pix_valid = 1'b0;
      end
    end
    @(negedge clk);
    pix_valid = 1'b1;
    pix = item;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    board.note_transfer(item);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    pix_valid = 1'b0;
    while (board.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [CFG_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = which;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(which, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Noise flushes land while the frame is filling and are dropped by the
  // block; drain ticks are mostly flushes, some pixels with junk data.
  task automatic run_frame(int unsigned noise_pct);
    int unsigned fw;
    int unsigned fh;
    fw = board.eff_width();
    fh = board.eff_height();
    for (int unsigned n = 0; n < fw * fh; n++) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(random_pixel(1'b1));
      send_item(random_pixel(1'b0));
    end
    for (int unsigned n = 0; n <= fw; n++)
      send_item(random_pixel($urandom_range(0, 3) != 0));
    stim_items += fw * fh + fw + 1;
  endtask

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0: return CFG_W'($urandom_range(0, 2));
      1: return CFG_W'($urandom_range(13, 40));
      default: return CFG_W'($urandom_range(3, 12));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_height();
    case ($urandom_range(0, 7))
      0: return CFG_W'($urandom_range(0, 2));
      default: return CFG_W'($urandom_range(3, 7));
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    pix_valid = 1'b0;
    pix = '0;
    res_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    calm = 1'b0;
    idle_pct_in = 0;
    idle_pct_out = 0;
    stim_items = 0;
    cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // smallest frame, both sizes clamped up to three
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    send_item(pixel_of(1'b1, 24'h123456));
    repeat (9) send_item(pixel_of(1'b0, 24'hFFFFFF));
    send_item(pixel_of(1'b1, 24'h000000));
    send_item(pixel_of(1'b0, 24'h5A5A5A));
    send_item(pixel_of(1'b1, 24'hFFFFFF));
    send_item(pixel_of(1'b0, 24'hA5A5A5));
    for (int i = 0; i < 9; i++)
      send_item(pixel_of(1'b0, (i % 2) ? 24'h000000 : 24'hFF01FE));
    repeat (4) send_item(pixel_of(1'b1, 24'h000000));

    while (stim_items < RANDOM_ITEMS) begin
      write_reg(REG_FRAME_WIDTH, pick_width());
      write_reg(REG_FRAME_HEIGHT, pick_height());
      idle_pct_in = pick_pct();
      idle_pct_out = pick_pct();
      run_frame($urandom_range(0, 1) ? 0 : 8);
    end

    // tall narrow frame
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, CFG_W'(60));
    idle_pct_in = 5;
    idle_pct_out = 5;
    run_frame(2);

    calm = 1'b1;
    repeat (3) begin
      write_reg(REG_FRAME_WIDTH, pick_width());
      write_reg(REG_FRAME_HEIGHT, pick_height());
      run_frame(5);
    end

    wait_drained();
    if (board.mismatches == 0 && board.expected_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/rbb_pkg.sv
src/rbb_window.sv
src/rbb_lane.sv
src/rbb_merge.sv
src/rgb_box_blur_3x3.sv
tb/testbench.sv
